/* rtl/core/jtl_pkg.sv */
`default_nettype none

package jtl_pkg;

  localparam int MAX_NUMBER_LEN_DEF  = 99;
  localparam int MAX_KEYWORD_LEN_DEF = 7;
  localparam int OUT_FIFO_DEPTH      = 4;

  // lexer modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_STRING  = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_KEYWORD = 3'd3;
  localparam logic [2:0] MODE_DONE    = 3'd4;
  localparam logic [2:0] MODE_ERROR   = 3'd5;

  // number grammar phases
  localparam logic [2:0] PH_MINUS = 3'd0;
  localparam logic [2:0] PH_ZERO  = 3'd1;
  localparam logic [2:0] PH_INT   = 3'd2;
  localparam logic [2:0] PH_DOT   = 3'd3;
  localparam logic [2:0] PH_FRAC  = 3'd4;
  localparam logic [2:0] PH_E     = 3'd5;
  localparam logic [2:0] PH_ESIGN = 3'd6;
  localparam logic [2:0] PH_EXP   = 3'd7;

  // token types
  localparam logic [3:0] TT_END    = 4'd0;
  localparam logic [3:0] TT_LBRACE = 4'd1;
  localparam logic [3:0] TT_RBRACE = 4'd2;
  localparam logic [3:0] TT_LBRACK = 4'd3;
  localparam logic [3:0] TT_RBRACK = 4'd4;
  localparam logic [3:0] TT_COLON  = 4'd5;
  localparam logic [3:0] TT_COMMA  = 4'd6;
  localparam logic [3:0] TT_TRUE   = 4'd7;
  localparam logic [3:0] TT_FALSE  = 4'd8;
  localparam logic [3:0] TT_NULL   = 4'd9;
  localparam logic [3:0] TT_STRING = 4'd10;
  localparam logic [3:0] TT_NUMBER = 4'd11;
  localparam logic [3:0] TT_ERROR  = 4'd12;

  // error codes
  localparam logic [2:0] ERR_NONE          = 3'd0;
  localparam logic [2:0] ERR_UNEXPECTED    = 3'd1;
  localparam logic [2:0] ERR_BAD_NUMBER    = 3'd2;
  localparam logic [2:0] ERR_BAD_KEYWORD   = 3'd3;
  localparam logic [2:0] ERR_END_IN_ESCAPE = 3'd4;
  localparam logic [2:0] ERR_NO_QUOTE      = 3'd5;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_TOKEN   = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [3:0] token_type;
    logic [7:0] payload_byte;
    logic [2:0] error_code;
    logic       last;
  } res_t;

  typedef struct packed {
    logic       stop;
    logic [2:0] phase;
  } phase_step_t;

  typedef struct packed {
    logic       emit;
    res_t       res;
    logic [2:0] mode;
    logic       num_start;
    logic [2:0] phase;
    logic       kw_start;
    logic       err;
  } idle_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic phase_accepts(input logic [2:0] ph);
    return (ph == PH_ZERO) || (ph == PH_INT) || (ph == PH_FRAC) || (ph == PH_EXP);
  endfunction

  function automatic res_t mk_token(input logic [3:0] tt, input logic [2:0] ec);
    res_t r;
    r              = '0;
    r.kind         = KIND_TOKEN;
    r.token_type   = tt;
    r.error_code   = ec;
    return r;
  endfunction

  function automatic res_t mk_payload(input logic [3:0] tt, input logic [7:0] c);
    res_t r;
    r              = '0;
    r.kind         = KIND_PAYLOAD;
    r.token_type   = tt;
    r.payload_byte = c;
    return r;
  endfunction

  function automatic phase_step_t phase_next(input logic [2:0] ph, input logic [7:0] c);
    phase_step_t s;
    logic        d;
    logic        e;
    logic        sgn;
    d   = is_digit(c);
    e   = (c == 8'h65) || (c == 8'h45);
    sgn = (c == 8'h2B) || (c == 8'h2D);
    s   = '{stop: 1'b1, phase: ph};
    unique case (ph)
      PH_MINUS: begin
        if (c == 8'h30) s = '{stop: 1'b0, phase: PH_ZERO};
        else if (d) s = '{stop: 1'b0, phase: PH_INT};
      end
      PH_ZERO: begin
        if (c == 8'h2E) s = '{stop: 1'b0, phase: PH_DOT};
        else if (e) s = '{stop: 1'b0, phase: PH_E};
      end
      PH_INT: begin
        if (d) s = '{stop: 1'b0, phase: PH_INT};
        else if (c == 8'h2E) s = '{stop: 1'b0, phase: PH_DOT};
        else if (e) s = '{stop: 1'b0, phase: PH_E};
      end
      PH_DOT: begin
        if (d) s = '{stop: 1'b0, phase: PH_FRAC};
      end
      PH_FRAC: begin
        if (d) s = '{stop: 1'b0, phase: PH_FRAC};
        else if (e) s = '{stop: 1'b0, phase: PH_E};
      end
      PH_E: begin
        if (d) s = '{stop: 1'b0, phase: PH_EXP};
        else if (sgn) s = '{stop: 1'b0, phase: PH_ESIGN};
      end
      PH_ESIGN: begin
        if (d) s = '{stop: 1'b0, phase: PH_EXP};
      end
      default: begin
        if (d) s = '{stop: 1'b0, phase: PH_EXP};
      end
    endcase
    return s;
  endfunction

  // byte seen between tokens
  function automatic idle_t idle_step(input logic [7:0] c);
    idle_t r;
    r      = '0;
    r.mode = MODE_IDLE;
    case (c) inside
      8'h20, 8'h09, 8'h0A, 8'h0D: ;
      8'h22: r.mode = MODE_STRING;
      8'h7B: begin r.emit = 1'b1; r.res = mk_token(TT_LBRACE, ERR_NONE); end
      8'h7D: begin r.emit = 1'b1; r.res = mk_token(TT_RBRACE, ERR_NONE); end
      8'h5B: begin r.emit = 1'b1; r.res = mk_token(TT_LBRACK, ERR_NONE); end
      8'h5D: begin r.emit = 1'b1; r.res = mk_token(TT_RBRACK, ERR_NONE); end
      8'h3A: begin r.emit = 1'b1; r.res = mk_token(TT_COLON, ERR_NONE); end
      8'h2C: begin r.emit = 1'b1; r.res = mk_token(TT_COMMA, ERR_NONE); end
      default: begin
        if ((c == 8'h2D) || is_digit(c)) begin
          r.mode      = MODE_NUMBER;
          r.num_start = 1'b1;
          r.phase     = (c == 8'h2D) ? PH_MINUS : ((c == 8'h30) ? PH_ZERO : PH_INT);
          r.emit      = 1'b1;
          r.res       = mk_payload(TT_NUMBER, c);
        end else if (is_alpha(c)) begin
          r.mode     = MODE_KEYWORD;
          r.kw_start = 1'b1;
        end else begin
          r.mode = MODE_ERROR;
          r.err  = 1'b1;
          r.emit = 1'b1;
          r.res  = mk_token(TT_ERROR, ERR_UNEXPECTED);
        end
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/jtl_out_fifo.sv */
`default_nettype none

module jtl_out_fifo
  import jtl_pkg::*;
#(
  parameter int DEPTH = OUT_FIFO_DEPTH
) (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  push0,
  input  wire  push1,
  input  res_t wr0,
  input  res_t wr1,
  output logic room,
  output logic out_valid,
  input  wire  out_ready,
  output res_t rd
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  res_t             mem [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [CNT_W-1:0] push_n;

  assign pop       = out_valid && out_ready;
  assign push_n    = CNT_W'(push0) + CNT_W'(push1);
  assign room      = (cnt_r <= CNT_W'(DEPTH - 2));
  assign out_valid = (cnt_r != '0);
  assign rd        = mem[rp_r];

  assign wp_nxt  = wp_r + PTR_W'(push_n);
  assign rp_nxt  = rp_r + PTR_W'(pop);
  assign cnt_nxt = cnt_r + push_n - CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) mem[wp_r] <= wr0;
    if (push1) mem[wp_r + PTR_W'(1)] <= wr1;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("output queue count beyond depth");

  a_push_order: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> push0)
    else $error("second result written without first");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push0 |-> room)
    else $error("result written into full queue");

endmodule

`default_nettype wire

/* rtl/core/json_token_lexer.sv */
`default_nettype none

// Streaming JSON lexer. One text byte (or the end-of-text beat, in_tlast high) is taken per
// clock while in_tready is high; the whole lexing step for that byte is done combinationally
// and its results, at most two, go into a four-entry output queue that drives out_*. A byte
// gives no result, one, or two (a number or keyword ended by the end of text or by a byte
// that itself gives a result), so sustained input rate is set by the output side at one
// result per clock while out_tready is high. in_tready drops only when fewer than two queue
// slots are free. Strings and numbers leave as payload beats (out_tuser low) followed by a
// token beat; out_tlast marks the final result of each input beat. Errors are sticky: every
// later input beat returns the same error token until reset. After the end token no more
// results come.
module json_token_lexer
  import jtl_pkg::*;
#(
  parameter int MAX_NUMBER_LEN  = MAX_NUMBER_LEN_DEF,
  parameter int MAX_KEYWORD_LEN = MAX_KEYWORD_LEN_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // [7:0] data_byte
  input  wire         in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,  // [3:0] token_type, [11:4] payload_byte, [14:12] error_code
  output logic        out_tuser,  // kind
  output logic        out_tlast   // last
);

  localparam int NL_W = $clog2(MAX_NUMBER_LEN + 1);
  localparam int KL_W = $clog2(MAX_KEYWORD_LEN + 1);
  localparam int KI_W = $clog2(MAX_KEYWORD_LEN);
  localparam logic [NL_W-1:0] NUM_MAX = NL_W'(MAX_NUMBER_LEN);
  localparam logic [KL_W-1:0] KW_MAX  = KL_W'(MAX_KEYWORD_LEN);

  logic [2:0]      mode_r, mode_nxt;
  logic [2:0]      phase_r, phase_nxt;
  logic [NL_W-1:0] nl_r, nl_nxt;
  logic [KL_W-1:0] kl_r, kl_nxt;
  logic            esc_r, esc_nxt;
  logic [2:0]      err_r, err_nxt;
  logic [7:0]      kw_r [MAX_KEYWORD_LEN];

  logic            accept;
  logic [7:0]      c;
  logic            eoi;
  idle_t           idl;
  phase_step_t     ps;
  res_t            r0, r1;
  logic            v0, v1;
  logic            use_idle0, use_idle1;
  logic            kw_wr;
  logic [KI_W-1:0] kw_wr_idx;
  logic            kw_true, kw_false, kw_null;
  logic [3:0]      kw_type;
  logic            num_ok;

  assign accept = in_tvalid && in_tready;
  assign c      = in_tdata;
  assign eoi    = in_tlast;
  assign idl    = idle_step(c);
  assign ps     = phase_next(phase_r, c);

  assign kw_true  = (kl_r == KL_W'(4)) && (kw_r[0] == 8'h74) && (kw_r[1] == 8'h72) &&
                    (kw_r[2] == 8'h75) && (kw_r[3] == 8'h65);
  assign kw_false = (kl_r == KL_W'(5)) && (kw_r[0] == 8'h66) && (kw_r[1] == 8'h61) &&
                    (kw_r[2] == 8'h6C) && (kw_r[3] == 8'h73) && (kw_r[4] == 8'h65);
  assign kw_null  = (kl_r == KL_W'(4)) && (kw_r[0] == 8'h6E) && (kw_r[1] == 8'h75) &&
                    (kw_r[2] == 8'h6C) && (kw_r[3] == 8'h6C);
  assign kw_type  = kw_true ? TT_TRUE : (kw_false ? TT_FALSE : TT_NULL);

  // a digit right after a leading zero is not a valid terminator
  assign num_ok = phase_accepts(phase_r) && !(!eoi && (phase_r == PH_ZERO) && is_digit(c));

  always_comb begin
    mode_nxt  = mode_r;
    phase_nxt = phase_r;
    nl_nxt    = nl_r;
    kl_nxt    = kl_r;
    esc_nxt   = esc_r;
    err_nxt   = err_r;
    v0        = 1'b0;
    v1        = 1'b0;
    r0        = '0;
    r1        = '0;
    use_idle0 = 1'b0;
    use_idle1 = 1'b0;
    kw_wr     = 1'b0;
    kw_wr_idx = kl_r[KI_W-1:0];
    unique case (mode_r)
      MODE_ERROR: begin
        v0 = 1'b1;
        r0 = mk_token(TT_ERROR, err_r);
      end
      MODE_DONE: ;
      MODE_STRING: begin
        if (eoi) begin
          mode_nxt = MODE_ERROR;
          err_nxt  = esc_r ? ERR_END_IN_ESCAPE : ERR_NO_QUOTE;
          v0       = 1'b1;
          r0       = mk_token(TT_ERROR, err_nxt);
        end else if (esc_r) begin
          esc_nxt = 1'b0;
          v0      = 1'b1;
          r0      = mk_payload(TT_STRING, c);
        end else if (c == 8'h5C) begin
          esc_nxt = 1'b1;
        end else if (c == 8'h22) begin
          mode_nxt = MODE_IDLE;
          v0       = 1'b1;
          r0       = mk_token(TT_STRING, ERR_NONE);
        end else begin
          v0 = 1'b1;
          r0 = mk_payload(TT_STRING, c);
        end
      end
      MODE_NUMBER: begin
        if (eoi || ps.stop) begin
          if (num_ok) begin
            v0       = 1'b1;
            r0       = mk_token(TT_NUMBER, ERR_NONE);
            mode_nxt = MODE_IDLE;
            nl_nxt   = '0;
            if (eoi) begin
              v1       = 1'b1;
              r1       = mk_token(TT_END, ERR_NONE);
              mode_nxt = MODE_DONE;
            end else begin
              use_idle1 = 1'b1;
            end
          end else begin
            mode_nxt = MODE_ERROR;
            err_nxt  = ERR_BAD_NUMBER;
            v0       = 1'b1;
            r0       = mk_token(TT_ERROR, ERR_BAD_NUMBER);
          end
        end else if (nl_r >= NUM_MAX) begin
          mode_nxt = MODE_ERROR;
          err_nxt  = ERR_BAD_NUMBER;
          v0       = 1'b1;
          r0       = mk_token(TT_ERROR, ERR_BAD_NUMBER);
        end else begin
          phase_nxt = ps.phase;
          nl_nxt    = nl_r + NL_W'(1);
          v0        = 1'b1;
          r0        = mk_payload(TT_NUMBER, c);
        end
      end
      MODE_KEYWORD: begin
        if (!eoi && is_alpha(c) && (kl_r < KW_MAX)) begin
          kw_wr  = 1'b1;
          kl_nxt = kl_r + KL_W'(1);
        end else if (kw_true || kw_false || kw_null) begin
          v0       = 1'b1;
          r0       = mk_token(kw_type, ERR_NONE);
          mode_nxt = MODE_IDLE;
          kl_nxt   = '0;
          if (eoi) begin
            v1       = 1'b1;
            r1       = mk_token(TT_END, ERR_NONE);
            mode_nxt = MODE_DONE;
          end else begin
            use_idle1 = 1'b1;
          end
        end else begin
          mode_nxt = MODE_ERROR;
          err_nxt  = ERR_BAD_KEYWORD;
          v0       = 1'b1;
          r0       = mk_token(TT_ERROR, ERR_BAD_KEYWORD);
        end
      end
      default: begin
        if (eoi) begin
          v0       = 1'b1;
          r0       = mk_token(TT_END, ERR_NONE);
          mode_nxt = MODE_DONE;
        end else begin
          use_idle0 = 1'b1;
        end
      end
    endcase

    // byte in idle mode, or a terminating byte, handled as between tokens
    if (use_idle0 || use_idle1) begin
      mode_nxt = idl.mode;
      if (idl.mode == MODE_STRING) esc_nxt = 1'b0;
      if (idl.num_start) begin
        phase_nxt = idl.phase;
        nl_nxt    = NL_W'(1);
      end
      if (idl.kw_start) begin
        kw_wr     = 1'b1;
        kw_wr_idx = '0;
        kl_nxt    = KL_W'(1);
      end
      if (idl.err) err_nxt = ERR_UNEXPECTED;
      if (use_idle0) begin
        v0 = idl.emit;
        r0 = idl.res;
      end else begin
        v1 = idl.emit;
        r1 = idl.res;
      end
    end

    if (v1) r1.last = 1'b1;
    else r0.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      phase_r <= PH_MINUS;
      nl_r    <= '0;
      kl_r    <= '0;
      esc_r   <= 1'b0;
      err_r   <= ERR_NONE;
    end else if (accept) begin
      mode_r  <= mode_nxt;
      phase_r <= phase_nxt;
      nl_r    <= nl_nxt;
      kl_r    <= kl_nxt;
      esc_r   <= esc_nxt;
      err_r   <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && kw_wr) kw_r[kw_wr_idx] <= c;
  end

  res_t rd;
  logic push0, push1;

  assign push0 = accept && v0;
  assign push1 = accept && v1;

  jtl_out_fifo #(
    .DEPTH(OUT_FIFO_DEPTH)
  ) u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push0     (push0),
    .push1     (push1),
    .wr0       (r0),
    .wr1       (r1),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .rd        (rd)
  );

  assign out_tdata = {1'b0, rd.error_code, rd.payload_byte, rd.token_type};
  assign out_tuser = rd.kind;
  assign out_tlast = rd.last;

  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (mode_r == MODE_DONE)) |-> (!push0 && !push1))
    else $error("result produced after end token");

  a_error_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (mode_r == MODE_ERROR)) |->
      (push0 && !push1 && (r0.token_type == TT_ERROR) && (r0.error_code == err_r)))
    else $error("halted lexer did not repeat its error");

  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_ERROR) |=> ((mode_r == MODE_ERROR) && $stable(err_r)))
    else $error("error state left before reset");

  a_kw_len: assert property (@(posedge clk) disable iff (!rst_n)
    kl_r <= KW_MAX)
    else $error("keyword length beyond limit");

endmodule

`default_nettype wire

/* tb/json_token_lexer_test.sv */
`timescale 1ns / 1ps

module json_token_lexer_test
  import jtl_pkg::*;
();

  localparam int ITEMS       = 2000;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 120;
  localparam int HOLD_AFTER  = 150;
  localparam int TAIL_CYCLES = 10;
  localparam int AFTER_HALT  = 30;

  localparam string WS_CHARS     = " \t\n\r";
  localparam string STRUCT_CHARS = "{}[]:,";
  localparam string DELIM_CHARS  = " \t\n\r{}[]:,";

  typedef struct packed {
    logic [7:0] b;
    logic       eoi;
    logic       typed;
    res_t       want;
  } row_t;

  typedef enum int {
    FIN_CLEAN, FIN_IN_NUMBER, FIN_IN_KEYWORD, FIN_IN_STRING, FIN_AFTER_ESCAPE,
    FIN_STRAY_BYTE, FIN_UNFINISHED_NUMBER, FIN_LEADING_ZERO, FIN_OVERLONG_NUMBER,
    FIN_UNKNOWN_WORD, FIN_LONG_WORD
  } finale_t;

  localparam res_t UNTYPED = '0;
  localparam int N_DIRECTED = 25;

  // typed rows hold a single result; the rest go through the lexer model below
  localparam row_t DIRECTED [N_DIRECTED] = '{
    '{" ",   1'b0, 1'b0, UNTYPED},
    '{"{",   1'b0, 1'b1, '{KIND_TOKEN,   TT_LBRACE, 8'h00, ERR_NONE, 1'b1}},
    '{"\"",  1'b0, 1'b0, UNTYPED},
    '{8'h00, 1'b0, 1'b1, '{KIND_PAYLOAD, TT_STRING, 8'h00, ERR_NONE, 1'b1}},
    '{8'hFF, 1'b0, 1'b1, '{KIND_PAYLOAD, TT_STRING, 8'hFF, ERR_NONE, 1'b1}},
    '{"\\",  1'b0, 1'b0, UNTYPED},
    '{"\"",  1'b0, 1'b1, '{KIND_PAYLOAD, TT_STRING, "\"",  ERR_NONE, 1'b1}},
    '{"\"",  1'b0, 1'b1, '{KIND_TOKEN,   TT_STRING, 8'h00, ERR_NONE, 1'b1}},
    '{":",   1'b0, 1'b1, '{KIND_TOKEN,   TT_COLON,  8'h00, ERR_NONE, 1'b1}},
    '{"[",   1'b0, 1'b1, '{KIND_TOKEN,   TT_LBRACK, 8'h00, ERR_NONE, 1'b1}},
    '{"-",   1'b0, 1'b1, '{KIND_PAYLOAD, TT_NUMBER, "-",   ERR_NONE, 1'b1}},
    '{"0",   1'b0, 1'b0, UNTYPED},
    '{".",   1'b0, 1'b0, UNTYPED},
    '{"5",   1'b0, 1'b0, UNTYPED},
    '{"E",   1'b0, 1'b0, UNTYPED},
    '{"+",   1'b0, 1'b0, UNTYPED},
    '{"9",   1'b0, 1'b0, UNTYPED},
    '{",",   1'b0, 1'b0, UNTYPED},
    '{"n",   1'b0, 1'b0, UNTYPED},
    '{"u",   1'b0, 1'b0, UNTYPED},
    '{"l",   1'b0, 1'b0, UNTYPED},
    '{"l",   1'b0, 1'b0, UNTYPED},
    '{"]",   1'b0, 1'b0, UNTYPED},
    '{"}",   1'b0, 1'b1, '{KIND_TOKEN,   TT_RBRACE, 8'h00, ERR_NONE, 1'b1}},
    '{8'h0D, 1'b0, 1'b0, UNTYPED}
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  json_token_lexer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // lexer model state
  logic [2:0] lx_mode;
  logic [2:0] num_phase;
  int         num_len;
  logic [7:0] kw_buf [MAX_KEYWORD_LEN_DEF];
  int         kw_len;
  logic       esc_pending;
  logic       lx_halted;
  logic [2:0] sticky_code;

  res_t       step_beats[$];
  res_t       expected_beats[$];
  logic [8:0] feed[$];

  logic    row_typed = 1'b0;
  res_t    row_want  = '0;
  logic    flood       = 1'b0;
  logic    source_calm = 1'b0;
  logic    sink_calm   = 1'b0;
  int      failures     = 0;
  int      items_taken  = 0;
  int      results_seen = 0;
  int      tokens_seen  = 0;
  int      quiet        = 0;
  finale_t finale;

  function automatic logic is_dec(input logic [7:0] c);
    return c inside {["0":"9"]};
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c inside {["a":"z"], ["A":"Z"]};
  endfunction

  // {stop, next phase}
  function automatic logic [3:0] number_advance(input logic [2:0] ph, input logic [7:0] c);
    logic dig;
    logic ex;
    dig = is_dec(c);
    ex  = (c == "e") || (c == "E");
    case (ph)
      PH_MINUS: if (c == "0") return {1'b0, PH_ZERO}; else if (dig) return {1'b0, PH_INT};
      PH_ZERO:  if (c == ".") return {1'b0, PH_DOT}; else if (ex) return {1'b0, PH_E};
      PH_INT: begin
        if (dig) return {1'b0, PH_INT};
        else if (c == ".") return {1'b0, PH_DOT};
        else if (ex) return {1'b0, PH_E};
      end
      PH_DOT:   if (dig) return {1'b0, PH_FRAC};
      PH_FRAC:  if (dig) return {1'b0, PH_FRAC}; else if (ex) return {1'b0, PH_E};
      PH_E: begin
        if (dig) return {1'b0, PH_EXP};
        else if ((c == "+") || (c == "-")) return {1'b0, PH_ESIGN};
      end
      default:  if (dig) return {1'b0, PH_EXP};
    endcase
    return {1'b1, ph};
  endfunction

  function automatic logic held_word(input string w);
    if (kw_len != w.len()) return 1'b0;
    for (int i = 0; i < w.len(); i++)
      if (kw_buf[i] != w[i]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic logic [3:0] keyword_kind();
    if (held_word("true")) return TT_TRUE;
    if (held_word("false")) return TT_FALSE;
    if (held_word("null")) return TT_NULL;
    return TT_ERROR;
  endfunction

  function automatic logic is_stray(input logic [7:0] c);
    return !(c inside {" ", 8'h09, 8'h0A, 8'h0D, "\"", "{", "}", "[", "]", ":", ",", "-"} ||
             is_dec(c) || is_letter(c));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0" + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'("a" + $urandom_range(0, 25)) : 8'("A" + $urandom_range(0, 25));
  endfunction

  task automatic lexer_clear();
    lx_mode     = MODE_IDLE;
    num_phase   = PH_MINUS;
    num_len     = 0;
    kw_len      = 0;
    esc_pending = 1'b0;
    lx_halted   = 1'b0;
    sticky_code = ERR_NONE;
    foreach (kw_buf[i]) kw_buf[i] = 8'h00;
  endtask

  task automatic put_token(input logic [3:0] tt, input logic [2:0] ec);
    step_beats.push_back('{KIND_TOKEN, tt, 8'h00, ec, 1'b0});
  endtask

  task automatic put_payload(input logic [3:0] tt, input logic [7:0] c);
    step_beats.push_back('{KIND_PAYLOAD, tt, c, ERR_NONE, 1'b0});
  endtask

  task automatic lexer_fail(input logic [2:0] code);
    lx_mode     = MODE_ERROR;
    lx_halted   = 1'b1;
    sticky_code = code;
    put_token(TT_ERROR, code);
  endtask

  task automatic lexer_end();
    lx_mode   = MODE_DONE;
    lx_halted = 1'b1;
    put_token(TT_END, ERR_NONE);
  endtask

  task automatic idle_byte(input logic [7:0] c);
    case (c)
      " ", 8'h09, 8'h0A, 8'h0D: ;
      "\"": begin
        lx_mode     = MODE_STRING;
        esc_pending = 1'b0;
      end
      "{": put_token(TT_LBRACE, ERR_NONE);
      "}": put_token(TT_RBRACE, ERR_NONE);
      "[": put_token(TT_LBRACK, ERR_NONE);
      "]": put_token(TT_RBRACK, ERR_NONE);
      ":": put_token(TT_COLON, ERR_NONE);
      ",": put_token(TT_COMMA, ERR_NONE);
      default: begin
        if ((c == "-") || is_dec(c)) begin
          lx_mode   = MODE_NUMBER;
          num_phase = (c == "-") ? PH_MINUS : ((c == "0") ? PH_ZERO : PH_INT);
          num_len   = 1;
          put_payload(TT_NUMBER, c);
        end else if (is_letter(c)) begin
          lx_mode   = MODE_KEYWORD;
          kw_buf[0] = c;
          kw_len    = 1;
        end else begin
          lexer_fail(ERR_UNEXPECTED);
        end
      end
    endcase
  endtask

  // one input beat -> step_beats, last flag set on the final one
  task automatic lex_step(input logic [7:0] c, input logic eoi);
    logic [3:0] nx;
    logic [3:0] tt;
    logic       ok;
    step_beats.delete();
    if (lx_halted) begin
      if (lx_mode == MODE_ERROR) put_token(TT_ERROR, sticky_code);
    end else if (lx_mode == MODE_STRING) begin
      if (eoi) lexer_fail(esc_pending ? ERR_END_IN_ESCAPE : ERR_NO_QUOTE);
      else if (esc_pending) begin
        esc_pending = 1'b0;
        put_payload(TT_STRING, c);
      end else if (c == "\\") begin
        esc_pending = 1'b1;
      end else if (c == "\"") begin
        lx_mode = MODE_IDLE;
        put_token(TT_STRING, ERR_NONE);
      end else begin
        put_payload(TT_STRING, c);
      end
    end else if (lx_mode == MODE_NUMBER) begin
      nx = eoi ? {1'b1, num_phase} : number_advance(num_phase, c);
      if (nx[3]) begin
        ok = (num_phase inside {PH_ZERO, PH_INT, PH_FRAC, PH_EXP}) &&
             !(!eoi && (num_phase == PH_ZERO) && is_dec(c));
        if (!ok) lexer_fail(ERR_BAD_NUMBER);
        else begin
          put_token(TT_NUMBER, ERR_NONE);
          lx_mode = MODE_IDLE;
          num_len = 0;
          if (eoi) lexer_end();
          else idle_byte(c);
        end
      end else if (num_len >= MAX_NUMBER_LEN_DEF) begin
        lexer_fail(ERR_BAD_NUMBER);
      end else begin
        num_phase = nx[2:0];
        num_len++;
        put_payload(TT_NUMBER, c);
      end
    end else if (lx_mode == MODE_KEYWORD) begin
      if (!eoi && is_letter(c) && (kw_len < MAX_KEYWORD_LEN_DEF)) begin
        kw_buf[kw_len] = c;
        kw_len++;
      end else begin
        tt = keyword_kind();
        if (tt == TT_ERROR) lexer_fail(ERR_BAD_KEYWORD);
        else begin
          put_token(tt, ERR_NONE);
          lx_mode = MODE_IDLE;
          kw_len  = 0;
          if (eoi) lexer_end();
          else idle_byte(c);
        end
      end
    end else begin
      lx_mode = MODE_IDLE;
      if (eoi) lexer_end();
      else idle_byte(c);
    end
    if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      failures++;
    end
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    logic took;
    took = 1'b0;
    if (rst_n) begin
      // results first: a beat accepted now was caused by an earlier input beat
      if (out_tvalid && out_tready) begin
        took = 1'b1;
        results_seen++;
        got = {out_tuser, out_tdata[3:0], out_tdata[11:4], out_tdata[14:12], out_tlast};
        if (got.kind == KIND_TOKEN) tokens_seen++;
        if (expected_beats.size() == 0) begin
          $error("result beat with nothing expected: kind %0d type %0d payload %0d error %0d",
                 got.kind, got.token_type, got.payload_byte, got.error_code);
          failures++;
        end else begin
          want = expected_beats.pop_front();
          check_field("kind", want.kind, got.kind);
          check_field("token_type", want.token_type, got.token_type);
          check_field("payload_byte", want.payload_byte, got.payload_byte);
          check_field("error_code", want.error_code, got.error_code);
          check_field("last", want.last, got.last);
        end
      end
      if (in_tvalid && in_tready) begin
        took = 1'b1;
        items_taken++;
        lex_step(in_tdata, in_tlast);
        if (row_typed) expected_beats.push_back(row_want);
        else foreach (step_beats[i]) expected_beats.push_back(step_beats[i]);
      end
      quiet = took ? 0 : quiet + 1;
      if (quiet >= STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_beats.size());
        $display("** json_token_lexer: FAILED **");
        $finish;
      end
    end
  end

  // result side: random stalls, one long hold to back the block up
  initial begin
    int  w;
    logic held;
    held      = 1'b0;
    sink_calm = $urandom_range(0, 1);
    @(posedge rst_n);
    forever begin
      if (!held && (results_seen >= HOLD_AFTER)) begin
        out_tready = 1'b0;
        flood      = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        flood = 1'b0;
        held  = 1'b1;
      end
      if ($urandom_range(0, 59) == 0) sink_calm = !sink_calm;
      w = sink_calm ? 0 : $urandom_range(0, 17);
      if (w > 0) begin
        out_tready = 1'b0;
        repeat (w) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic eoi, input logic typed,
                           input res_t want);
    int gap;
    if ($urandom_range(0, 59) == 0) source_calm = !source_calm;
    gap = (source_calm || flood) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = b;
    in_tlast  = eoi;
    row_typed = typed;
    row_want  = want;
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic push_text(input logic [7:0] b);
    feed.push_back({1'b0, b});
  endtask

  task automatic push_close();
    feed.push_back({1'b1, 8'($urandom_range(0, 255))});
  endtask

  task automatic pick_from(input string s);
    push_text(s[$urandom_range(0, s.len() - 1)]);
  endtask

  task automatic push_word(input string w);
    foreach (w[i]) push_text(w[i]);
  endtask

  task automatic add_string(input logic closed);
    logic [7:0] b;
    push_text("\"");
    repeat ($urandom_range(0, 12)) begin
      b = 8'($urandom_range(0, 255));
      // escape quote and backslash, plus a few arbitrary bytes
      if ((b == "\"") || (b == "\\") || ($urandom_range(0, 7) == 0)) push_text("\\");
      push_text(b);
    end
    if (closed) push_text("\"");
  endtask

  task automatic add_number(input logic longest);
    if (longest) begin
      push_text(8'("1" + $urandom_range(0, 8)));
      repeat (MAX_NUMBER_LEN_DEF - 1) push_text(rand_digit());
    end else begin
      if ($urandom_range(0, 2) == 0) push_text("-");
      if ($urandom_range(0, 3) == 0) push_text("0");
      else begin
        push_text(8'("1" + $urandom_range(0, 8)));
        repeat ($urandom_range(0, 3)) push_text(rand_digit());
      end
      if ($urandom_range(0, 1)) begin
        push_text(".");
        repeat ($urandom_range(1, 3)) push_text(rand_digit());
      end
      if ($urandom_range(0, 2) == 0) begin
        push_text($urandom_range(0, 1) ? "e" : "E");
        case ($urandom_range(0, 2))
          0: push_text("+");
          1: push_text("-");
          default: ;
        endcase
        repeat ($urandom_range(1, 3)) push_text(rand_digit());
      end
    end
  endtask

  task automatic add_keyword();
    case ($urandom_range(0, 2))
      0: push_word("true");
      1: push_word("false");
      default: push_word("null");
    endcase
  endtask

  // close the stream: the clean end or one sticky error
  task automatic add_finale(input finale_t f);
    logic [7:0] b;
    case (f)
      FIN_CLEAN: push_close();
      FIN_IN_NUMBER: begin
        add_number(1'b0);
        push_close();
      end
      FIN_IN_KEYWORD: begin
        add_keyword();
        push_close();
      end
      FIN_IN_STRING: begin
        add_string(1'b0);
        push_close();
      end
      FIN_AFTER_ESCAPE: begin
        add_string(1'b0);
        push_text("\\");
        push_close();
      end
      FIN_STRAY_BYTE: begin
        do b = 8'($urandom_range(0, 255)); while (!is_stray(b));
        push_text(b);
      end
      FIN_UNFINISHED_NUMBER: begin
        case ($urandom_range(0, 3))
          0: push_word("-");
          1: push_word("1.");
          2: push_word("2e");
          default: push_word("3E-");
        endcase
        if ($urandom_range(0, 1)) push_close();
        else pick_from(DELIM_CHARS);
      end
      FIN_LEADING_ZERO: begin
        if ($urandom_range(0, 1)) push_text("-");
        push_text("0");
        push_text(rand_digit());
      end
      FIN_OVERLONG_NUMBER: begin
        add_number(1'b1);
        push_text(rand_digit());
      end
      FIN_UNKNOWN_WORD: begin
        push_text(8'("A" + $urandom_range(0, 25)));
        repeat ($urandom_range(0, 5)) push_text(rand_letter());
        if ($urandom_range(0, 1)) push_close();
        else pick_from(DELIM_CHARS);
      end
      default: repeat (MAX_KEYWORD_LEN_DEF + 1) push_text(rand_letter());
    endcase
  endtask

  initial begin
    lexer_clear();
    source_calm = $urandom_range(0, 1);
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (DIRECTED[i])
      send_beat(DIRECTED[i].b, DIRECTED[i].eoi, DIRECTED[i].typed, DIRECTED[i].want);

    // errors are sticky, so keep the text well formed until the finale
    while (feed.size() < ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: pick_from(STRUCT_CHARS);
        2: repeat ($urandom_range(1, 3)) pick_from(WS_CHARS);
        3, 4, 5: add_string(1'b1);
        6, 7: begin
          add_number($urandom_range(0, 39) == 0);
          pick_from(DELIM_CHARS);
        end
        default: begin
          add_keyword();
          pick_from(DELIM_CHARS);
        end
      endcase
    end
    finale = finale_t'($urandom_range(FIN_CLEAN, FIN_LONG_WORD));
    add_finale(finale);
    repeat (AFTER_HALT) feed.push_back(9'($urandom_range(0, 511)));
    foreach (feed[i]) send_beat(feed[i][7:0], feed[i][8], 1'b0, UNTYPED);
    in_tvalid = 1'b0;

    while (expected_beats.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("lexed %0d input beats into %0d result beats, %0d of them tokens",
             items_taken, results_seen, tokens_seen);
    $display("text closed by %s, then %0d beats after halt; one %0d-cycle output hold",
             finale.name(), AFTER_HALT, HOLD_CYCLES);
    if (failures == 0) begin
      $display("** json_token_lexer: PASSED **");
    end else begin
      $display("** json_token_lexer: FAILED **");
    end
    $finish;
  end

endmodule
